### rtl/edva_pkg.sv
// Shared types and constants for the encoder detent value adjust unit.
`default_nettype none

package edva_pkg;

    localparam int COUNTS_PER_DETENT = 4;

    localparam int COUNT_W  = 16;
    localparam int VALUE_W  = 32;
    localparam int STEP_W   = 16;
    localparam int DETENT_W = 14;

    // Stream payload layout.
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 48;

    // APB register map.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    typedef enum logic [1:0] {
        REG_STEP_SIZE   = 2'd0,
        REG_UPPER_LIMIT = 2'd1,
        REG_LOWER_LIMIT = 2'd2,
        REG_START_VALUE = 2'd3
    } t_reg_idx;

    localparam logic signed [STEP_W-1:0]  STEP_SIZE_RST   = 16'sd1;
    localparam logic signed [VALUE_W-1:0] UPPER_LIMIT_RST = 32'sh7fff_ffff;
    localparam logic signed [VALUE_W-1:0] LOWER_LIMIT_RST = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] START_VALUE_RST = 32'sd0;

    localparam logic ACTION_SAMPLE = 1'b0;
    localparam logic ACTION_START  = 1'b1;

    typedef struct packed {
        logic signed [STEP_W-1:0]  step_size;
        logic signed [VALUE_W-1:0] upper_limit;
        logic signed [VALUE_W-1:0] lower_limit;
        logic signed [VALUE_W-1:0] start_value;
    } t_cfg;

    typedef struct packed {
        logic signed [VALUE_W-1:0]  adjusted_value;
        logic signed [DETENT_W-1:0] detent_steps;
        logic                       moved;
    } t_result;

endpackage

`default_nettype wire

### rtl/edva_regs.sv
// APB configuration register file for the detent value adjust unit.
`default_nettype none

module edva_regs
    import edva_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[3:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_size   <= STEP_SIZE_RST;
            r_cfg.upper_limit <= UPPER_LIMIT_RST;
            r_cfg.lower_limit <= LOWER_LIMIT_RST;
            r_cfg.start_value <= START_VALUE_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_STEP_SIZE:   r_cfg.step_size   <= pwdata[STEP_W-1:0];
                REG_UPPER_LIMIT: r_cfg.upper_limit <= pwdata[VALUE_W-1:0];
                REG_LOWER_LIMIT: r_cfg.lower_limit <= pwdata[VALUE_W-1:0];
                REG_START_VALUE: r_cfg.start_value <= pwdata[VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            REG_STEP_SIZE:   prdata = APB_DATA_W'(r_cfg.step_size);
            REG_UPPER_LIMIT: prdata = APB_DATA_W'(r_cfg.upper_limit);
            REG_LOWER_LIMIT: prdata = APB_DATA_W'(r_cfg.lower_limit);
            REG_START_VALUE: prdata = APB_DATA_W'(r_cfg.start_value);
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### rtl/edva_calc.sv
// Detent count, value update, saturation and clamping for one sample.
`default_nettype none

module edva_calc
    import edva_pkg::*;
(
    input  wire logic                      i_action,
    input  wire logic        [COUNT_W-1:0] i_count,
    input  wire logic        [COUNT_W-1:0] i_ref,
    input  wire logic signed [VALUE_W-1:0] i_value,
    input  t_cfg                           i_cfg,
    output logic             [COUNT_W-1:0] o_ref,
    output t_result                        o_res
);

    localparam logic signed [COUNT_W:0]   CPD_S   = (COUNT_W+1)'(COUNTS_PER_DETENT);
    localparam logic signed [VALUE_W+1:0] SAT_MAX = (VALUE_W+2)'(UPPER_LIMIT_RST);
    localparam logic signed [VALUE_W+1:0] SAT_MIN = (VALUE_W+2)'(LOWER_LIMIT_RST);

    logic signed [COUNT_W-1:0]         w_gap;
    logic signed [COUNT_W:0]           w_quot;
    logic signed [COUNT_W-1:0]         w_detents;
    logic signed [COUNT_W:0]           w_ref_step;
    logic signed [STEP_W+COUNT_W-1:0]  w_prod;
    logic signed [VALUE_W+1:0]         w_sum;
    logic signed [VALUE_W-1:0]         w_sat;
    logic signed [VALUE_W-1:0]         w_hi;
    logic signed [VALUE_W-1:0]         w_clamped;
    logic                              w_moved;

    // Signed division truncates toward zero, so small gaps give no detent.
    assign w_gap      = signed'(i_count - i_ref);
    assign w_quot     = (COUNT_W+1)'(w_gap) / CPD_S;
    assign w_detents  = w_quot[COUNT_W-1:0];
    assign w_moved    = (w_detents != '0);
    assign w_ref_step = (COUNT_W+1)'(w_detents) * CPD_S;

    assign w_prod = (STEP_W+COUNT_W)'(i_cfg.step_size) * (STEP_W+COUNT_W)'(w_detents);
    assign w_sum  = (VALUE_W+2)'(i_value) + (VALUE_W+2)'(w_prod);

    always_comb begin
        if (w_sum > SAT_MAX) begin
            w_sat = UPPER_LIMIT_RST;
        end else if (w_sum < SAT_MIN) begin
            w_sat = LOWER_LIMIT_RST;
        end else begin
            w_sat = w_sum[VALUE_W-1:0];
        end
        w_hi      = (w_sat > i_cfg.upper_limit) ? i_cfg.upper_limit : w_sat;
        w_clamped = (w_hi < i_cfg.lower_limit) ? i_cfg.lower_limit : w_hi;
    end

    always_comb begin
        if (i_action == ACTION_START) begin
            o_ref                = i_count;
            o_res.adjusted_value = i_cfg.start_value;
            o_res.detent_steps   = '0;
            o_res.moved          = 1'b0;
        end else if (w_moved) begin
            o_ref                = i_ref + w_ref_step[COUNT_W-1:0];
            o_res.adjusted_value = w_clamped;
            o_res.detent_steps   = w_detents[DETENT_W-1:0];
            o_res.moved          = 1'b1;
        end else begin
            o_ref                = i_ref;
            o_res.adjusted_value = i_value;
            o_res.detent_steps   = '0;
            o_res.moved          = 1'b0;
        end
    end

endmodule

`default_nettype wire

### rtl/encoder_detent_value_adjust_unit.sv
// Top level: stream in counter readings, stream out adjusted values and detent counts.
// A sample is held in the input register; its result is then registered and shown until taken.
// Throughput: one item per cycle while the output is not stalled; the reference and value loop
// closes through the detent, multiply and clamp logic between input and result registers.
// Reset (synchronous, active low) empties both stages, clears reference and value,
// and returns the registers to their defaults.
`default_nettype none

module encoder_detent_value_adjust_unit
    import edva_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // APB configuration
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    // Input stream
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [S_TDATA_W-1:0]  i_s_tdata,   // [15:0] counter_value
    input  wire logic                  i_s_tuser,   // [0] action
    // Output stream
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    output logic      [M_TDATA_W-1:0]  o_m_tdata,   // [31:0] adjusted_value, [45:32] detent_steps
    output logic                       o_m_tuser    // [0] moved
);

    t_cfg                      w_cfg;
    t_result                   w_res;
    logic        [COUNT_W-1:0] w_ref_next;
    logic                      w_advance;
    logic                      w_in_take;

    logic                      r_in_valid;
    logic                      r_in_action;
    logic        [COUNT_W-1:0] r_in_count;
    logic        [COUNT_W-1:0] r_ref;
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_out_valid;
    t_result                   r_out;

    edva_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    edva_calc u_calc (
        .i_action (r_in_action),
        .i_count  (r_in_count),
        .i_ref    (r_ref),
        .i_value  (r_value),
        .i_cfg    (w_cfg),
        .o_ref    (w_ref_next),
        .o_res    (w_res)
    );

    // Advance the held sample whenever the result register is free or drains.
    assign w_advance  = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_advance;
    assign w_in_take  = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_ref       <= '0;
            r_value     <= '0;
        end else begin
            if (w_in_take) begin
                r_in_valid <= 1'b1;
            end else if (w_advance) begin
                r_in_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
                r_ref       <= w_ref_next;
                r_value     <= w_res.adjusted_value;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_take) begin
            r_in_action <= i_s_tuser;
            r_in_count  <= i_s_tdata[COUNT_W-1:0];
        end
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-VALUE_W-DETENT_W){1'b0}},
                         r_out.detent_steps, r_out.adjusted_value};
    assign o_m_tuser  = r_out.moved;

endmodule

`default_nettype wire

### rtl/edva_checker.sv
// Port-level checks for the detent value adjust unit, bound to the top level.
`default_nettype none

module edva_checker
    import edva_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 o_s_tready,
    input wire logic                 o_m_tvalid,
    input wire logic                 i_m_tready,
    input wire logic [M_TDATA_W-1:0] o_m_tdata,
    input wire logic                 o_m_tuser
);

    // Reset empties the output stage.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

    // A stalled result holds.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // With no result pending the input side must be open.
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output");

    // No movement means no detents reported.
    a_no_move_no_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tuser |-> o_m_tdata[45:32] == '0)
        else $error("detents reported without movement");

    // Padding above the detent field stays zero.
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[47:46] == '0)
        else $error("nonzero padding in result");

endmodule

bind encoder_detent_value_adjust_unit edva_checker u_edva_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

`default_nettype wire
